/* rtl/vertex_normal_accumulator_top_assert.svh */
// Assertion macros used by the top-level RTL
`ifndef VERTEX_NORMAL_ACCUMULATOR_TOP_ASSERT_SVH
`define VERTEX_NORMAL_ACCUMULATOR_TOP_ASSERT_SVH
// implication checked every clock outside reset
`define VNA_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// next-cycle implication checked every clock outside reset
`define VNA_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

/* rtl/vna_pkg.sv */
`default_nettype none
package vna_pkg;
   localparam int VertexSlotsDef    = 1024;
   localparam int AccumWidthDef     = 24;
   localparam int NormalFracBitsDef = 14;
   localparam int PosWidth          = 16;
   localparam int OutWidth          = 16;
   localparam int IdxWidth          = 10;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_TRI  = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;
endpackage
`default_nettype wire

/* rtl/vertex_normal_accumulator_top.sv */
`default_nettype none
// Ops: a load or an unused op leaves busy low; an in-range triangle or a read
// keeps busy high until it is done, and a read strobes its result while busy is
// still high; the shared normalizer's align loop makes both lengths data-dependent.
// Throughput: one item at a time; busy is high until the item is done.
// Reset: synchronous, active high; a clearing pass over all VERTEX_SLOTS
// slots follows reset, with busy high, to zero the accumulators.
module vertex_normal_accumulator_top #(
   parameter int VERTEX_SLOTS     = vna_pkg::VertexSlotsDef,
   parameter int ACCUM_WIDTH      = vna_pkg::AccumWidthDef,
   parameter int NORMAL_FRAC_BITS = vna_pkg::NormalFracBitsDef
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [1:0]                            req_op,
   input  wire logic [vna_pkg::IdxWidth-1:0]          req_vertex_addr,
   input  wire logic signed [vna_pkg::PosWidth-1:0]   req_pos_x,
   input  wire logic signed [vna_pkg::PosWidth-1:0]   req_pos_y,
   input  wire logic signed [vna_pkg::PosWidth-1:0]   req_pos_z,
   input  wire logic [vna_pkg::IdxWidth-1:0]          req_corner_a,
   input  wire logic [vna_pkg::IdxWidth-1:0]          req_corner_b,
   input  wire logic [vna_pkg::IdxWidth-1:0]          req_corner_c,
   output logic                                       rsp_strobe,
   output logic signed [vna_pkg::OutWidth-1:0]        rsp_norm_x,
   output logic signed [vna_pkg::OutWidth-1:0]        rsp_norm_y,
   output logic signed [vna_pkg::OutWidth-1:0]        rsp_norm_z,
   output logic                                       rsp_no_normal
);
   import vna_pkg::*;
   `include "vertex_normal_accumulator_top_assert.svh"

   localparam int AW   = $clog2(VERTEX_SLOTS);
   localparam int PW   = 3 * PosWidth;
   localparam int AccW = 3 * ACCUM_WIDTH + 1;
   localparam int NW   = NORMAL_FRAC_BITS + 2;
   localparam int CW   = 36;
   localparam logic signed [ACCUM_WIDTH+1:0] AccHi =
      (ACCUM_WIDTH+2)'((64'sd1 <<< (ACCUM_WIDTH - 1)) - 1);
   localparam logic signed [ACCUM_WIDTH+1:0] AccLo = -AccHi - 1;
   localparam int OutMax = 32767;
   localparam int OutMin = -32768;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_PRD, S_PWAIT, S_CROSS, S_CROSS2, S_NORM,
      S_ARD, S_AWR, S_RRD, S_RNORM, S_RESP
   } state_type;

   state_type state_ff;
   logic [AW:0]  clr_ff;
   logic [1:0]   k_ff;
   logic [AW-1:0] idx_ff [3];
   logic [AW-1:0] raddr_ff;
   logic signed [PosWidth:0] ex_ff [3];
   logic signed [PosWidth:0] fx_ff [3];
   logic signed [PosWidth-1:0] p0_ff [3];
   logic signed [CW-1:0] cr_ff [3];
   logic norm_start_ff;
   logic signed [NW-1:0] n_ff [3];
   logic signed [39:0] nin [3];
   logic signed [NW-1:0] nout [3];
   logic norm_done, norm_valid;
   logic strobe_ff, nonorm_ff;
   logic signed [OutWidth-1:0] ox_ff, oy_ff, oz_ff;
   logic rd_miss_ff;
   logic accept;
   logic rsp_zero;
   logic signed [2*PosWidth+1:0] prod_a [3];
   logic signed [2*PosWidth+1:0] prod_b [3];

   // memories
   logic          pw_en, aw_en;
   logic [AW-1:0] pw_addr, pr_addr, aw_addr, ar_addr;
   logic [PW-1:0] pw_data, pr_data;
   logic [AccW-1:0] aw_data, ar_data;

   vna_ram #(.Width(PW), .Depth(VERTEX_SLOTS)) u_pos (
      .clock(clock), .wr_en(pw_en), .wr_addr(pw_addr), .wr_data(pw_data),
      .rd_addr(pr_addr), .rd_data(pr_data));
   vna_ram #(.Width(AccW), .Depth(VERTEX_SLOTS)) u_acc (
      .clock(clock), .wr_en(aw_en), .wr_addr(aw_addr), .wr_data(aw_data),
      .rd_addr(ar_addr), .rd_data(ar_data));

   vna_norm #(.InWidth(40), .FracBits(NORMAL_FRAC_BITS)) u_norm (
      .clock(clock), .reset(reset), .start(norm_start_ff),
      .in_x(nin[0]), .in_y(nin[1]), .in_z(nin[2]),
      .done(norm_done), .valid(norm_valid),
      .out_x(nout[0]), .out_y(nout[1]), .out_z(nout[2]));

   logic signed [ACCUM_WIDTH-1:0] acc_rd [3];
   logic signed [ACCUM_WIDTH+1:0] acc_sum [3];
   logic signed [ACCUM_WIDTH-1:0] acc_new [3];
   logic in_range;
   logic [AW-1:0] pos_idx;

   function automatic logic signed [OutWidth-1:0] sat16(input logic signed [NW-1:0] v);
      if (v > OutMax)      sat16 = OutWidth'(OutMax);
      else if (v < OutMin) sat16 = OutWidth'(OutMin);
      else                 sat16 = OutWidth'(v);
   endfunction

   always_comb begin
      accept = start && !busy;
      prod_a[0] = ex_ff[1] * fx_ff[2];
      prod_a[1] = ex_ff[2] * fx_ff[0];
      prod_a[2] = ex_ff[0] * fx_ff[1];
      prod_b[0] = ex_ff[2] * fx_ff[1];
      prod_b[1] = ex_ff[0] * fx_ff[2];
      prod_b[2] = ex_ff[1] * fx_ff[0];
      for (int i = 0; i < 3; i++) begin
         acc_rd[i]  = ar_data[i*ACCUM_WIDTH +: ACCUM_WIDTH];
         acc_sum[i] = (ACCUM_WIDTH+2)'(acc_rd[i]) + (ACCUM_WIDTH+2)'(n_ff[i]);
         if (acc_sum[i] > AccHi)      acc_new[i] = ACCUM_WIDTH'(AccHi);
         else if (acc_sum[i] < AccLo) acc_new[i] = ACCUM_WIDTH'(AccLo);
         else                         acc_new[i] = ACCUM_WIDTH'(acc_sum[i]);
      end
      if (state_ff == S_RNORM || state_ff == S_RRD) begin
         for (int i = 0; i < 3; i++) nin[i] = 40'(acc_rd[i]);
      end else begin
         for (int i = 0; i < 3; i++) nin[i] = 40'(cr_ff[i]);
      end
      in_range = (32'(req_corner_a) < VERTEX_SLOTS) && (32'(req_corner_b) < VERTEX_SLOTS)
                 && (32'(req_corner_c) < VERTEX_SLOTS);
      pos_idx  = idx_ff[k_ff];
      pr_addr  = (state_ff == S_IDLE) ? AW'(req_corner_a) : pos_idx;
      pw_en    = (state_ff == S_IDLE) && accept && (req_op == OP_LOAD)
                 && (32'(req_vertex_addr) < VERTEX_SLOTS);
      pw_addr  = AW'(req_vertex_addr);
      pw_data  = {req_pos_z, req_pos_y, req_pos_x};
      ar_addr  = (state_ff == S_IDLE) ? AW'(req_vertex_addr) :
                 (state_ff == S_RRD || state_ff == S_RNORM) ? raddr_ff :
                 (state_ff == S_NORM) ? idx_ff[0] : idx_ff[k_ff];
      aw_en    = 1'b0;
      aw_addr  = idx_ff[k_ff];
      aw_data  = {1'b1, acc_new[2], acc_new[1], acc_new[0]};
      if (state_ff == S_CLEAR) begin
         aw_en = 1'b1; aw_addr = clr_ff[AW-1:0]; aw_data = '0;
      end else if (pw_en) begin
         aw_en = 1'b1; aw_addr = AW'(req_vertex_addr); aw_data = '0;
      end else if (state_ff == S_AWR) begin
         aw_en = 1'b1;
      end
   end

   // control sequence
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         strobe_ff     <= 1'b0;
         norm_start_ff <= 1'b0;
      end else begin
         strobe_ff     <= 1'b0;
         norm_start_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + (AW+1)'(1);
               if (clr_ff == (AW+1)'(VERTEX_SLOTS - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (accept) begin
                  idx_ff[0] <= AW'(req_corner_a);
                  idx_ff[1] <= AW'(req_corner_b);
                  idx_ff[2] <= AW'(req_corner_c);
                  raddr_ff  <= AW'(req_vertex_addr);
                  rd_miss_ff <= !(32'(req_vertex_addr) < VERTEX_SLOTS);
                  k_ff      <= 2'd1;
                  if (req_op == OP_TRI && in_range) state_ff <= S_PRD;
                  else if (req_op == OP_READ) state_ff <= S_RRD;
               end
            end
            S_PRD: begin
               // collect corner a, then b and c
               if (k_ff == 2'd1) begin
                  for (int i = 0; i < 3; i++) p0_ff[i] <= pr_data[i*PosWidth +: PosWidth];
                  k_ff <= 2'd2;
               end else begin
                  for (int i = 0; i < 3; i++)
                     ex_ff[i] <= (PosWidth+1)'($signed(pr_data[i*PosWidth +: PosWidth]))
                                 - (PosWidth+1)'(p0_ff[i]);
                  state_ff <= S_PWAIT;
               end
            end
            S_PWAIT: begin
               for (int i = 0; i < 3; i++)
                  fx_ff[i] <= (PosWidth+1)'($signed(pr_data[i*PosWidth +: PosWidth]))
                              - (PosWidth+1)'(p0_ff[i]);
               state_ff <= S_CROSS;
            end
            S_CROSS: begin
               for (int i = 0; i < 3; i++) cr_ff[i] <= CW'(prod_a[i]);
               state_ff <= S_CROSS2;
            end
            S_CROSS2: begin
               for (int i = 0; i < 3; i++) cr_ff[i] <= cr_ff[i] - CW'(prod_b[i]);
               norm_start_ff <= 1'b1;
               state_ff <= S_NORM;
            end
            S_NORM: begin
               if (norm_done) begin
                  for (int i = 0; i < 3; i++) n_ff[i] <= norm_valid ? nout[i] : '0;
                  k_ff     <= '0;
                  state_ff <= S_ARD;
               end
            end
            S_ARD: state_ff <= S_AWR;
            S_AWR: begin
               // next corner reads after this write lands
               if (k_ff == 2'd2) state_ff <= S_IDLE;
               else begin
                  k_ff <= k_ff + 2'd1;
                  state_ff <= S_ARD;
               end
            end
            S_RRD: begin
               if (rd_miss_ff || !ar_data[AccW-1]) begin
                  nonorm_ff <= 1'b1;
                  ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
                  state_ff <= S_RESP;
               end else begin
                  norm_start_ff <= 1'b1;
                  state_ff <= S_RNORM;
               end
            end
            S_RNORM: begin
               if (norm_done) begin
                  nonorm_ff <= !norm_valid;
                  ox_ff <= norm_valid ? sat16(nout[0]) : '0;
                  oy_ff <= norm_valid ? sat16(nout[1]) : '0;
                  oz_ff <= norm_valid ? sat16(nout[2]) : '0;
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               strobe_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy          = (state_ff != S_IDLE) || strobe_ff;
   assign rsp_strobe    = strobe_ff;
   assign rsp_norm_x    = ox_ff;
   assign rsp_norm_y    = oy_ff;
   assign rsp_norm_z    = oz_ff;
   assign rsp_no_normal = nonorm_ff;
   assign rsp_zero      = (rsp_norm_x == 0) && (rsp_norm_y == 0) && (rsp_norm_z == 0);

   `VNA_ASSERT_IMP(a_strobe_busy, clock, reset, rsp_strobe, busy)
   `VNA_ASSERT_NEXT(a_resp_strobe, clock, reset, state_ff == S_RESP, rsp_strobe)
   `VNA_ASSERT_IMP(a_nonorm_zero, clock, reset, rsp_strobe && rsp_no_normal, rsp_zero)
endmodule
`default_nettype wire

/* rtl/vna_ram.sv */
`default_nettype none
module vna_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/vna_norm.sv */
`default_nettype none
// Scale a vector to unit length: align, square sum, bit-serial root, then
// one restoring divide per component, one quotient bit a cycle.
module vna_norm #(
   parameter int InWidth  = 40,
   parameter int FracBits = 14
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic signed [InWidth-1:0] in_x,
   input  wire logic signed [InWidth-1:0] in_y,
   input  wire logic signed [InWidth-1:0] in_z,
   output logic                           done,
   output logic                           valid,
   output logic signed [FracBits+1:0]     out_x,
   output logic signed [FracBits+1:0]     out_y,
   output logic signed [FracBits+1:0]     out_z
);
   import vna_pkg::*;

   localparam int MagW  = InWidth;
   localparam int NumW  = 31 + FracBits + 1;
   localparam int QW    = FracBits + 2;
   localparam int CntW  = $clog2(NumW + 34);

   typedef enum logic [2:0] {
      S_IDLE, S_ALIGN, S_SQ, S_ROOT, S_DIV, S_DONE
   } state_type;

   state_type state_ff;
   logic [MagW-1:0]  mag_ff [3];
   logic [2:0]       neg_ff;
   logic [1:0]       comp_ff;
   logic [63:0]      sum_ff;
   logic [63:0]      rem_ff;
   logic [63:0]      root_ff;
   logic [63:0]      bit_ff;
   logic [NumW-1:0]  num_ff;
   logic [NumW:0]    drem_ff;
   logic [QW-1:0]    q_ff [3];
   logic [CntW-1:0]  cnt_ff;
   logic             valid_ff;
   logic [MagW-1:0]  max_mag;
   logic [63:0]      sq;
   logic [63:0]      trial;
   logic [NumW:0]    dtrial;
   logic [31:0]      half;

   always_comb begin
      max_mag = mag_ff[0];
      if (mag_ff[1] > max_mag) max_mag = mag_ff[1];
      if (mag_ff[2] > max_mag) max_mag = mag_ff[2];
      sq     = 64'(mag_ff[comp_ff][30:0]) * 64'(mag_ff[comp_ff][30:0]);
      trial  = root_ff + bit_ff;
      half   = 32'(root_ff >> 1);
      dtrial = {drem_ff[NumW-1:0], num_ff[NumW-1]} - (NumW+1)'(root_ff);
   end

   // sequence align, squares, root and division
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  mag_ff[0] <= in_x[InWidth-1] ? MagW'(-in_x) : MagW'(in_x);
                  mag_ff[1] <= in_y[InWidth-1] ? MagW'(-in_y) : MagW'(in_y);
                  mag_ff[2] <= in_z[InWidth-1] ? MagW'(-in_z) : MagW'(in_z);
                  neg_ff    <= {in_z[InWidth-1], in_y[InWidth-1], in_x[InWidth-1]};
                  state_ff  <= S_ALIGN;
               end
            end
            S_ALIGN: begin
               // one shift step a cycle until the largest sits in [2^30, 2^31), or stop on a zero vector
               if (max_mag == '0) begin
                  valid_ff <= 1'b0;
                  state_ff <= S_DONE;
               end else if (max_mag >= (MagW'(1) << 31)) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
               end else if (max_mag < (MagW'(1) << 30)) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 1;
               end else begin
                  sum_ff   <= '0;
                  comp_ff  <= '0;
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               sum_ff <= sum_ff + sq;
               if (comp_ff == 2'd2) begin
                  root_ff  <= '0;
                  bit_ff   <= 64'd1 << 62;
                  rem_ff   <= sum_ff + sq;
                  state_ff <= S_ROOT;
               end else begin
                  comp_ff <= comp_ff + 2'd1;
               end
            end
            S_ROOT: begin
               if (bit_ff == '0) begin
                  comp_ff  <= '0;
                  num_ff   <= (NumW'(mag_ff[0][30:0]) << FracBits) + NumW'(half);
                  drem_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end else begin
                  if (rem_ff >= trial) begin
                     rem_ff  <= rem_ff - trial;
                     root_ff <= (root_ff >> 1) + bit_ff;
                  end else begin
                     root_ff <= root_ff >> 1;
                  end
                  bit_ff <= bit_ff >> 2;
               end
            end
            S_DIV: begin
               if (dtrial[NumW] == 1'b0) begin
                  drem_ff <= dtrial;
                  q_ff[comp_ff] <= {q_ff[comp_ff][QW-2:0], 1'b1};
               end else begin
                  drem_ff <= {drem_ff[NumW-1:0], num_ff[NumW-1]};
                  q_ff[comp_ff] <= {q_ff[comp_ff][QW-2:0], 1'b0};
               end
               num_ff <= num_ff << 1;
               if (cnt_ff == CntW'(NumW - 1)) begin
                  cnt_ff <= '0;
                  drem_ff <= '0;
                  if (comp_ff == 2'd2) begin
                     valid_ff <= 1'b1;
                     state_ff <= S_DONE;
                  end else begin
                     comp_ff <= comp_ff + 2'd1;
                     num_ff  <= (NumW'(mag_ff[comp_ff + 2'd1][30:0]) << FracBits)
                                + NumW'(half);
                  end
               end else begin
                  cnt_ff <= cnt_ff + CntW'(1);
               end
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done  = (state_ff == S_DONE);
   assign valid = valid_ff;
   assign out_x = neg_ff[0] ? -$signed(q_ff[0]) : $signed(q_ff[0]);
   assign out_y = neg_ff[1] ? -$signed(q_ff[1]) : $signed(q_ff[1]);
   assign out_z = neg_ff[2] ? -$signed(q_ff[2]) : $signed(q_ff[2]);
endmodule
`default_nettype wire
